FILE: hw/rtl/bracket_loop_tape_machine_core_defines.svh
// Assertion macros used by the tape machine sequencer.
`ifndef BRACKET_LOOP_TAPE_MACHINE_CORE_DEFINES_SVH
`define BRACKET_LOOP_TAPE_MACHINE_CORE_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define BLT_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Same-cycle implication.
`define BLT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BLT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/blt_pkg.sv
// Shared types, constants and codes of the tape machine.
package blt_pkg;

  localparam int PROG_DEPTH = 4096;
  localparam int TAPE_DEPTH = 1024;
  localparam int PROG_AW    = $clog2(PROG_DEPTH);
  localparam int PLEN_W     = $clog2(PROG_DEPTH + 1);
  localparam int TAPE_AW    = $clog2(TAPE_DEPTH);

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int FAULT_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REWIND = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [FAULT_W-1:0] FLT_NONE     = 2'd0;
  localparam logic [FAULT_W-1:0] FLT_BAD_CHAR = 2'd1;
  localparam logic [FAULT_W-1:0] FLT_OPEN     = 2'd2;
  localparam logic [FAULT_W-1:0] FLT_CLOSE    = 2'd3;

  localparam logic [BYTE_W-1:0] CH_RIGHT   = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LEFT    = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_INC     = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_DEC     = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_OUT     = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_IN      = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_OPEN    = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE   = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_COMMENT = 8'h23;
  localparam logic [BYTE_W-1:0] CH_SP      = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT      = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF      = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;

  typedef enum logic [3:0] {
    OP_BLANK,
    OP_RIGHT,
    OP_LEFT,
    OP_INC,
    OP_DEC,
    OP_OUT,
    OP_IN,
    OP_OPEN,
    OP_CLOSE,
    OP_COMMENT,
    OP_BAD
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] code_byte;
    logic              last_code;
    logic [BYTE_W-1:0] in_byte;
  } item_t;

  typedef struct packed {
    logic               out_valid;
    logic [BYTE_W-1:0]  out_byte;
    logic               took_input;
    logic               halted;
    logic [FAULT_W-1:0] fault;
  } res_t;

endpackage

FILE: hw/rtl/blt_if.sv
// Valid/ready channel interfaces for command words and result words.
interface blt_cmd_if import blt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] code_byte;
  logic              last_code;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, cmd, code_byte, last_code, in_byte, input ready);
  modport sink   (input valid, cmd, code_byte, last_code, in_byte, output ready);
endinterface

interface blt_res_if import blt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               took_input;
  logic               halted;
  logic [FAULT_W-1:0] fault;

  modport source (output valid, out_valid, out_byte, took_input, halted, fault, input ready);
  modport sink   (input valid, out_valid, out_byte, took_input, halted, fault, output ready);
endinterface

FILE: hw/rtl/blt_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module blt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/blt_decode.sv
// Program character decoder.
module blt_decode import blt_pkg::*; (
  input  logic [BYTE_W-1:0] ch,
  output op_t               op
);

  always_comb begin
    case (ch)
      CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: op = OP_BLANK;
      CH_RIGHT:   op = OP_RIGHT;
      CH_LEFT:    op = OP_LEFT;
      CH_INC:     op = OP_INC;
      CH_DEC:     op = OP_DEC;
      CH_OUT:     op = OP_OUT;
      CH_IN:      op = OP_IN;
      CH_OPEN:    op = OP_OPEN;
      CH_CLOSE:   op = OP_CLOSE;
      CH_COMMENT: op = OP_COMMENT;
      default:    op = OP_BAD;
    endcase
  end

endmodule

FILE: hw/rtl/blt_exec.sv
// Sequencer: loads, rewinds, single steps, program scans and tape clearing pass.
`include "bracket_loop_tape_machine_core_defines.svh"

module blt_exec import blt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  item_t              item,
  output logic               item_ready,
  input  logic               slot_free,
  output logic               done,
  output res_t               res,
  output logic               prog_we,
  output logic [PROG_AW-1:0] prog_waddr,
  output logic [BYTE_W-1:0]  prog_wdata,
  output logic [PROG_AW-1:0] prog_raddr,
  input  logic [BYTE_W-1:0]  prog_rdata,
  output logic               tape_we,
  output logic [TAPE_AW-1:0] tape_waddr,
  output logic [BYTE_W-1:0]  tape_wdata,
  output logic [TAPE_AW-1:0] tape_raddr,
  input  logic [BYTE_W-1:0]  tape_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_FWD,
    S_SCAN_BWD,
    S_COMMENT,
    S_CLEAR,
    S_WAIT
  } state_t;

  state_t             state, state_next;
  logic [PLEN_W-1:0]  plen, plen_next;
  logic [PROG_AW-1:0] load_pos, load_pos_next;
  logic [PLEN_W-1:0]  cp, cp_next;
  logic [TAPE_AW-1:0] cell_ptr, cell_ptr_next;
  logic [FAULT_W-1:0] fault, fault_next;
  logic [PLEN_W-1:0]  scan_idx, scan_idx_next;
  logic [PLEN_W-1:0]  depth, depth_next;
  logic               primed, primed_next;
  logic [TAPE_AW-1:0] clr_idx, clr_idx_next;
  logic               clr_reply, clr_reply_next;
  logic [BYTE_W-1:0]  in_byte_q;
  logic               res_ov, res_ti;
  logic [BYTE_W-1:0]  res_ob;

  logic               fin;
  logic               fin_ov, fin_ti;
  logic [BYTE_W-1:0]  fin_ob;
  logic [PLEN_W-1:0]  depth_step;
  op_t                op;

  blt_decode u_decode (
    .ch (prog_rdata),
    .op (op)
  );

  assign item_ready = (state == S_IDLE);
  assign prog_waddr = load_pos;
  assign prog_wdata = item.code_byte;
  assign tape_raddr = cell_ptr;

  always_comb begin
    state_next     = state;
    plen_next      = plen;
    load_pos_next  = load_pos;
    cp_next        = cp;
    cell_ptr_next  = cell_ptr;
    fault_next     = fault;
    scan_idx_next  = scan_idx;
    depth_next     = depth;
    primed_next    = primed;
    clr_idx_next   = clr_idx;
    clr_reply_next = clr_reply;
    fin            = 1'b0;
    fin_ov         = 1'b0;
    fin_ob         = '0;
    fin_ti         = 1'b0;
    prog_we        = 1'b0;
    prog_raddr     = cp[PROG_AW-1:0];
    tape_we        = 1'b0;
    tape_waddr     = cell_ptr;
    tape_wdata     = '0;
    depth_step     = depth;

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (item.cmd)
            CMD_LOAD: begin
              prog_we = 1'b1;
              if (item.last_code) begin
                plen_next     = PLEN_W'(load_pos) + 1'b1;
                load_pos_next = '0;
              end else if (load_pos == PROG_AW'(PROG_DEPTH - 1)) begin
                load_pos_next = '0;
              end else begin
                load_pos_next = load_pos + 1'b1;
              end
              fin = 1'b1;
            end
            CMD_STEP: begin
              if (fault != FLT_NONE || cp >= plen) begin
                fin = 1'b1;
              end else begin
                state_next = S_EXEC;
              end
            end
            CMD_REWIND: begin
              cp_next    = '0;
              fault_next = FLT_NONE;
              fin        = 1'b1;
            end
            CMD_CLEAR: begin
              cp_next        = '0;
              fault_next     = FLT_NONE;
              cell_ptr_next  = '0;
              clr_idx_next   = '0;
              clr_reply_next = 1'b1;
              state_next     = S_CLEAR;
            end
            default: fin = 1'b1;
          endcase
        end
      end

      S_EXEC: begin
        cp_next = cp + 1'b1;
        fin     = 1'b1;
        case (op)
          OP_BLANK: ;
          OP_RIGHT: begin
            if (cell_ptr == TAPE_AW'(TAPE_DEPTH - 1)) begin
              cell_ptr_next = '0;
            end else begin
              cell_ptr_next = cell_ptr + 1'b1;
            end
          end
          OP_LEFT: begin
            if (cell_ptr == '0) begin
              cell_ptr_next = TAPE_AW'(TAPE_DEPTH - 1);
            end else begin
              cell_ptr_next = cell_ptr - 1'b1;
            end
          end
          OP_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 8'd1;
          end
          OP_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 8'd1;
          end
          OP_OUT: begin
            fin_ov = 1'b1;
            fin_ob = tape_rdata;
          end
          OP_IN: begin
            tape_we    = 1'b1;
            tape_wdata = in_byte_q;
            fin_ti     = 1'b1;
          end
          OP_OPEN: begin
            if (tape_rdata == '0) begin
              cp_next       = cp;
              fin           = 1'b0;
              scan_idx_next = cp + 1'b1;
              depth_next    = PLEN_W'(1);
              primed_next   = 1'b0;
              state_next    = S_SCAN_FWD;
            end
          end
          OP_CLOSE: begin
            if (tape_rdata != '0) begin
              cp_next       = cp;
              fin           = 1'b0;
              scan_idx_next = cp;
              depth_next    = PLEN_W'(1);
              primed_next   = 1'b0;
              state_next    = S_SCAN_BWD;
            end
          end
          OP_COMMENT: begin
            cp_next       = cp;
            fin           = 1'b0;
            scan_idx_next = cp + 1'b1;
            primed_next   = 1'b0;
            state_next    = S_COMMENT;
          end
          default: begin
            cp_next    = cp;
            fault_next = FLT_BAD_CHAR;
          end
        endcase
      end

      // scan_idx is the next address to read; data in hand is scan_idx - 1
      S_SCAN_FWD: begin
        prog_raddr = scan_idx[PROG_AW-1:0];
        if (op == OP_OPEN) begin
          depth_step = depth + 1'b1;
        end else if (op == OP_CLOSE) begin
          depth_step = depth - 1'b1;
        end
        if (primed && depth_step == '0) begin
          cp_next = scan_idx;
          fin     = 1'b1;
        end else if (scan_idx >= plen) begin
          fault_next = FLT_OPEN;
          fin        = 1'b1;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
          primed_next   = 1'b1;
          if (primed) begin
            depth_next = depth_step;
          end
        end
      end

      // scan_idx is the address of the data in hand
      S_SCAN_BWD: begin
        prog_raddr = PROG_AW'(scan_idx - 1'b1);
        if (op == OP_CLOSE) begin
          depth_step = depth + 1'b1;
        end else if (op == OP_OPEN) begin
          depth_step = depth - 1'b1;
        end
        if (primed && depth_step == '0) begin
          cp_next = scan_idx + 1'b1;
          fin     = 1'b1;
        end else if (scan_idx == '0) begin
          fault_next = FLT_CLOSE;
          fin        = 1'b1;
        end else begin
          scan_idx_next = scan_idx - 1'b1;
          primed_next   = 1'b1;
          if (primed) begin
            depth_next = depth_step;
          end
        end
      end

      // a CR LF pair ends at its LF, so only LF is searched for
      S_COMMENT: begin
        prog_raddr = scan_idx[PROG_AW-1:0];
        if (primed && prog_rdata == CH_LF) begin
          cp_next = scan_idx;
          fin     = 1'b1;
        end else if (scan_idx >= plen) begin
          cp_next = plen;
          fin     = 1'b1;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
          primed_next   = 1'b1;
        end
      end

      S_CLEAR: begin
        tape_we      = 1'b1;
        tape_waddr   = clr_idx;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == TAPE_AW'(TAPE_DEPTH - 1)) begin
          if (clr_reply) begin
            fin = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      S_WAIT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    if (fin) begin
      state_next = slot_free ? S_IDLE : S_WAIT;
    end
  end

  always_comb begin
    done           = (fin || state == S_WAIT) && slot_free;
    res.out_valid  = (state == S_WAIT) ? res_ov : fin_ov;
    res.out_byte   = (state == S_WAIT) ? res_ob : fin_ob;
    res.took_input = (state == S_WAIT) ? res_ti : fin_ti;
    res.halted     = (cp_next >= plen_next);
    res.fault      = fault_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      plen      <= '0;
      load_pos  <= '0;
      cp        <= '0;
      cell_ptr  <= '0;
      fault     <= FLT_NONE;
      depth     <= '0;
      primed    <= 1'b0;
      clr_idx   <= '0;
      clr_reply <= 1'b0;
    end else begin
      state     <= state_next;
      plen      <= plen_next;
      load_pos  <= load_pos_next;
      cp        <= cp_next;
      cell_ptr  <= cell_ptr_next;
      fault     <= fault_next;
      depth     <= depth_next;
      primed    <= primed_next;
      clr_idx   <= clr_idx_next;
      clr_reply <= clr_reply_next;
    end
    scan_idx <= scan_idx_next;
    if (item_valid && item_ready) begin
      in_byte_q <= item.in_byte;
    end
    if (fin) begin
      res_ov <= fin_ov;
      res_ob <= fin_ob;
      res_ti <= fin_ti;
    end
  end

  `BLT_CHECK(a_done_slot, !done || slot_free, "result issued while output slot busy")
  `BLT_NEXT(a_faulted_step_holds, item_valid && item_ready && item.cmd == CMD_STEP && fault != FLT_NONE, $stable(cp) && $stable(cell_ptr), "faulted step changed machine state")
  `BLT_NEXT(a_clear_rewinds, item_valid && item_ready && item.cmd == CMD_CLEAR, cp == '0 && cell_ptr == '0 && state == S_CLEAR, "clear did not rewind and start sweep")
  `BLT_IMPLIES(a_scan_depth, state == S_SCAN_FWD || state == S_SCAN_BWD, depth != '0, "bracket scan running at zero depth")

endmodule

FILE: hw/rtl/bracket_loop_tape_machine_core.sv
// Top level of the bracket-loop tape machine.
//
// cmd_ch takes command words: load a program byte, execute one step, rewind
// the code pointer, or clear the tape and rewind. Every accepted word gives
// exactly one result word on res_ch, in order.
// From accept to result in the output register: load and rewind finish in
// the accept state; a simple step (move, add, I/O, blank) goes on to an
// execute state, which takes the program and tape read data and does the tape
// read-modify-write; a taken bracket or a comment then scans one program
// byte at a time, set by the single program store read port; clear writes
// all TAPE_DEPTH cells (1024), one tape cell written per cycle. One word is
// worked on at a time. After reset all TAPE_DEPTH tape cells are swept to zero
// with cmd_ch.ready low; no result word is produced by that sweep.
// When res_ch stalls, the pending result stays in the output register and the
// next command word may still be accepted; its result waits until the
// register drains, with cmd_ch.ready low meanwhile.
module bracket_loop_tape_machine_core import blt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  blt_cmd_if.sink   cmd_ch,
  blt_res_if.source res_ch
);

  item_t              item;
  res_t               res, res_q;
  logic               res_valid;
  logic               slot_free;
  logic               done;
  logic               item_ready;

  logic               prog_we;
  logic [PROG_AW-1:0] prog_waddr, prog_raddr;
  logic [BYTE_W-1:0]  prog_wdata, prog_rdata;
  logic               tape_we;
  logic [TAPE_AW-1:0] tape_waddr, tape_raddr;
  logic [BYTE_W-1:0]  tape_wdata, tape_rdata;

  assign item.cmd       = cmd_ch.cmd;
  assign item.code_byte = cmd_ch.code_byte;
  assign item.last_code = cmd_ch.last_code;
  assign item.in_byte   = cmd_ch.in_byte;
  assign cmd_ch.ready   = item_ready;

  assign slot_free = !res_valid || res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
    if (done) begin
      res_q <= res;
    end
  end

  assign res_ch.valid      = res_valid;
  assign res_ch.out_valid  = res_q.out_valid;
  assign res_ch.out_byte   = res_q.out_byte;
  assign res_ch.took_input = res_q.took_input;
  assign res_ch.halted     = res_q.halted;
  assign res_ch.fault      = res_q.fault;

  blt_ram #(.WIDTH(BYTE_W), .DEPTH(PROG_DEPTH)) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (prog_wdata),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  blt_ram #(.WIDTH(BYTE_W), .DEPTH(TAPE_DEPTH)) u_tape_ram (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (tape_raddr),
    .rdata (tape_rdata)
  );

  blt_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .item_valid (cmd_ch.valid),
    .item       (item),
    .item_ready (item_ready),
    .slot_free  (slot_free),
    .done       (done),
    .res        (res),
    .prog_we    (prog_we),
    .prog_waddr (prog_waddr),
    .prog_wdata (prog_wdata),
    .prog_raddr (prog_raddr),
    .prog_rdata (prog_rdata),
    .tape_we    (tape_we),
    .tape_waddr (tape_waddr),
    .tape_wdata (tape_wdata),
    .tape_raddr (tape_raddr),
    .tape_rdata (tape_rdata)
  );

endmodule

FILE: dv/blt_step_monitor.sv
// Monitor for the tape machine: predicts each result word and compares it.
module blt_step_monitor import blt_pkg::*; (
  input  logic clk,
  input  logic rst,
  blt_cmd_if   cmd_mon,
  blt_res_if   res_mon,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [BYTE_W-1:0]  prog_mem [PROG_DEPTH];
  logic [BYTE_W-1:0]  tape_mem [TAPE_DEPTH];
  logic [PLEN_W-1:0]  prog_len;
  logic [PLEN_W-1:0]  prog_ctr;
  logic [PROG_AW-1:0] load_pos;
  logic [TAPE_AW-1:0] cell_ptr;
  logic [FAULT_W-1:0] fault_q;

  res_t step_results_due[$];

  function automatic void wipe_tape();
    foreach (tape_mem[k]) tape_mem[k] = '0;
  endfunction

  function automatic void run_step(input logic [BYTE_W-1:0] ib, inout res_t r);
    int cp;
    int i;
    int depth;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] cur_val;
    logic [BYTE_W-1:0] d;
    bit found;
    cp = int'(prog_ctr);
    c = prog_mem[cp];
    cur_val = tape_mem[cell_ptr];
    case (c)
      CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: begin
        prog_ctr = PLEN_W'(cp + 1);
        return;
      end
      CH_RIGHT: cell_ptr = (cell_ptr == TAPE_AW'(TAPE_DEPTH - 1)) ? '0 : cell_ptr + 1'b1;
      CH_LEFT:  cell_ptr = (cell_ptr == '0) ? TAPE_AW'(TAPE_DEPTH - 1) : cell_ptr - 1'b1;
      CH_INC:   tape_mem[cell_ptr] = cur_val + 1'b1;
      CH_DEC:   tape_mem[cell_ptr] = cur_val - 1'b1;
      CH_OUT: begin
        r.out_valid = 1'b1;
        r.out_byte = cur_val;
      end
      CH_IN: begin
        tape_mem[cell_ptr] = ib;
        r.took_input = 1'b1;
      end
      CH_OPEN: begin
        if (cur_val == '0) begin
          depth = 1;
          for (i = cp + 1; i < prog_len; i++) begin
            d = prog_mem[i];
            if (d == CH_OPEN) depth++;
            else if (d == CH_CLOSE) depth--;
            if (depth == 0) break;
          end
          if (i >= prog_len) begin
            fault_q = FLT_OPEN;
            return;
          end
          cp = i;
        end
      end
      CH_CLOSE: begin
        if (cur_val != '0) begin
          depth = 1;
          i = cp;
          found = 1'b0;
          while (i > 0) begin
            i--;
            d = prog_mem[i];
            if (d == CH_CLOSE) depth++;
            else if (d == CH_OPEN) depth--;
            if (depth == 0) begin
              found = 1'b1;
              break;
            end
          end
          if (!found) begin
            fault_q = FLT_CLOSE;
            return;
          end
          cp = i;
        end
      end
      CH_COMMENT: begin
        i = cp;
        while (i < prog_len) begin
          if (prog_mem[i] == CH_CR && i + 1 < prog_len && prog_mem[i + 1] == CH_LF) begin
            i++;
            break;
          end
          if (prog_mem[i] == CH_LF) break;
          i++;
        end
        if (i >= prog_len) begin
          prog_ctr = prog_len;
          return;
        end
        cp = i;
      end
      default: begin
        fault_q = FLT_BAD_CHAR;
        return;
      end
    endcase
    prog_ctr = PLEN_W'(cp + 1);
  endfunction

  function automatic res_t apply_command(item_t w);
    res_t r;
    r = '0;
    case (w.cmd)
      CMD_LOAD: begin
        prog_mem[load_pos] = w.code_byte;
        if (w.last_code) begin
          prog_len = PLEN_W'(load_pos) + 1'b1;
          load_pos = '0;
        end else begin
          load_pos = (load_pos == PROG_AW'(PROG_DEPTH - 1)) ? '0 : load_pos + 1'b1;
        end
      end
      CMD_STEP: begin
        if (fault_q == FLT_NONE && prog_ctr < prog_len) run_step(w.in_byte, r);
      end
      CMD_REWIND, CMD_CLEAR: begin
        if (w.cmd == CMD_CLEAR) begin
          wipe_tape();
          cell_ptr = '0;
        end
        prog_ctr = '0;
        fault_q = FLT_NONE;
      end
      default: ;
    endcase
    r.halted = (prog_ctr >= prog_len);
    r.fault = fault_q;
    return r;
  endfunction

  function automatic int field_differs(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    item_t w;
    int bad;
    if (rst) begin
      foreach (prog_mem[k]) prog_mem[k] = '0;
      wipe_tape();
      prog_len = '0;
      prog_ctr = '0;
      load_pos = '0;
      cell_ptr = '0;
      fault_q = FLT_NONE;
      step_results_due.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      bad = 0;
      // drain before predicting: a word never yields its result on its own accept edge
      if (res_mon.valid && res_mon.ready) begin
        got.out_valid = res_mon.out_valid;
        got.out_byte = res_mon.out_byte;
        got.took_input = res_mon.took_input;
        got.halted = res_mon.halted;
        got.fault = res_mon.fault;
        if (step_results_due.size() == 0) begin
          $error("result word with nothing expected");
          bad++;
        end else begin
          want = step_results_due.pop_front();
          bad += field_differs("out_valid", want.out_valid, got.out_valid);
          bad += field_differs("out_byte", want.out_byte, got.out_byte);
          bad += field_differs("took_input", want.took_input, got.took_input);
          bad += field_differs("halted", want.halted, got.halted);
          bad += field_differs("fault", want.fault, got.fault);
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        w.cmd = cmd_mon.cmd;
        w.code_byte = cmd_mon.code_byte;
        w.last_code = cmd_mon.last_code;
        w.in_byte = cmd_mon.in_byte;
        step_results_due.insert(step_results_due.size(), apply_command(w));
      end
      mismatches <= mismatches + bad;
      pending <= step_results_due.size();
    end
  end

endmodule

FILE: dv/bracket_loop_tape_machine_core_tb.sv
// Testbench top: drives program loads, steps, rewinds and clears into the tape machine and gives the verdict.
module bracket_loop_tape_machine_core_tb;
  import blt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst;

  blt_cmd_if cmd_ch ();
  blt_res_if res_ch ();

  int mismatches;
  int pending;
  int words_sent = 0;
  int stalled_cycles = 0;
  bit quiet = 1'b0;
  bit calm = 1'b0;
  bit held_long = 1'b0;

  logic [BYTE_W-1:0] code_buf[$];

  bracket_loop_tape_machine_core dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  blt_step_monitor mon (
    .clk        (clk),
    .rst        (rst),
    .cmd_mon    (cmd_ch),
    .res_mon    (res_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  task automatic send_word(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b,
                           input logic l, input logic [BYTE_W-1:0] ib);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= c;
    cmd_ch.code_byte <= b;
    cmd_ch.last_code <= l;
    cmd_ch.in_byte <= ib;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic load_code();
    for (int k = 0; k < code_buf.size(); k++)
      send_word(CMD_LOAD, code_buf[k], k == code_buf.size() - 1, BYTE_W'($urandom));
  endtask

  task automatic run_steps(input int n);
    repeat (n) send_word(CMD_STEP, BYTE_W'($urandom), 1'($urandom_range(0, 1)),
                         BYTE_W'($urandom));
  endtask

  // balanced brackets, nesting up to 3, comments ended by LF, CR LF or nothing
  function automatic void compose_program();
    int len;
    int depth;
    int pick;
    logic [BYTE_W-1:0] b;
    code_buf.delete();
    depth = 0;
    len = $urandom_range(3, 36);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        case ($urandom_range(0, 5))
          0: b = CH_RIGHT;
          1: b = CH_LEFT;
          2: b = CH_INC;
          3: b = CH_DEC;
          4: b = CH_OUT;
          default: b = CH_IN;
        endcase
        code_buf.insert(code_buf.size(), b);
      end else if (pick < 13) begin
        if (depth < 3) begin
          code_buf.insert(code_buf.size(), CH_OPEN);
          depth++;
        end
      end else if (pick < 16) begin
        if (depth > 0) begin
          code_buf.insert(code_buf.size(), CH_CLOSE);
          depth--;
        end
      end else if (pick < 18) begin
        case ($urandom_range(0, 5))
          0: b = CH_SP;
          1: b = CH_TAB;
          2: b = CH_LF;
          3: b = CH_VT;
          4: b = CH_FF;
          default: b = CH_CR;
        endcase
        code_buf.insert(code_buf.size(), b);
      end else begin
        code_buf.insert(code_buf.size(), CH_COMMENT);
        repeat ($urandom_range(0, 4))
          code_buf.insert(code_buf.size(), BYTE_W'(8'h61 + $urandom_range(0, 25)));
        if (pick == 18) begin
          code_buf.insert(code_buf.size(), CH_LF);
        end else if ($urandom_range(0, 3) != 0) begin
          code_buf.insert(code_buf.size(), CH_CR);
          code_buf.insert(code_buf.size(), CH_LF);
        end
      end
    end
    while (depth > 0) begin
      code_buf.insert(code_buf.size(), CH_CLOSE);
      depth--;
    end
  endfunction

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_long && words_sent >= 300) begin
        // long back-pressure so the core fills and drops cmd ready
        held_long = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= 5000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0] b;
    logic [CMD_W-1:0] c;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_LOAD;
    cmd_ch.code_byte = '0;
    cmd_ch.last_code = 1'b0;
    cmd_ch.in_byte = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // tape wrap both ways, 8-bit wrap, output, input, taken bracket, CR LF comment,
    // unpaired close with jump taken, step while faulted, then clear
    code_buf = {CH_LEFT, CH_RIGHT, CH_DEC, CH_OUT, CH_INC, CH_OPEN, CH_CLOSE,
                CH_COMMENT, CH_CR, CH_LF, CH_IN, CH_OUT, CH_CLOSE};
    load_code();
    repeat (11) send_word(CMD_STEP, 8'h00, 1'b0, 8'hA5);
    send_word(CMD_CLEAR, 8'hFF, 1'b1, 8'hFF);

    while (words_sent < 900) begin
      quiet = (words_sent >= 820);
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        compose_program();
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 2))
            0: b = CH_OPEN;
            1: b = CH_CLOSE;
            default: b = BYTE_W'($urandom_range(0, 255));
          endcase
          code_buf.insert($urandom_range(0, code_buf.size()), b);
        end
        load_code();
        if ($urandom_range(0, 19) == 0)
          send_word(CMD_CLEAR, BYTE_W'($urandom), 1'($urandom_range(0, 1)),
                    BYTE_W'($urandom));
        else if ($urandom_range(0, 4) != 0)
          send_word(CMD_REWIND, BYTE_W'($urandom), 1'($urandom_range(0, 1)),
                    BYTE_W'($urandom));
        run_steps($urandom_range(4, 40));
      end else begin
        repeat ($urandom_range(3, 12)) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: c = CMD_LOAD;
            4, 5, 6, 7: c = CMD_STEP;
            8: c = CMD_REWIND;
            default: c = CMD_CLEAR;
          endcase
          send_word(c, BYTE_W'($urandom), $urandom_range(0, 3) == 0, BYTE_W'($urandom));
        end
      end
    end

    quiet = 1'b1;
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/blt_pkg.sv
hw/rtl/blt_if.sv
hw/rtl/blt_ram.sv
hw/rtl/blt_decode.sv
hw/rtl/blt_exec.sv
hw/rtl/bracket_loop_tape_machine_core.sv
dv/blt_step_monitor.sv
dv/bracket_loop_tape_machine_core_tb.sv
